FILE: rtl/lkd_pkg.sv
// lkd_pkg: shared constants, codes and types for the key list block
// no dependencies
`default_nettype none

package lkd_pkg;

  localparam int CAPACITY = 32;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_DEL_KEY   = 3'd1;
  localparam logic [2:0] OP_DEL_FIRST = 3'd2;
  localparam logic [2:0] OP_DEL_LAST  = 3'd3;
  localparam logic [2:0] OP_DUMP      = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic insert;
    logic del_key;
    logic del_first;
    logic rotate;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/lkd_cell.sv
// lkd_cell: one list position, holds a key and shifts towards its neighbours
// depends on lkd_pkg
`default_nettype none

module lkd_cell (
  input  wire                     clk,
  input  wire lkd_pkg::cell_ctl_t ctl,
  input  wire lkd_pkg::key_t      key,
  input  wire lkd_pkg::key_t      left_data,
  input  wire lkd_pkg::key_t      right_data,
  input  wire lkd_pkg::key_t      head_data,
  input  wire                     occupied,
  input  wire                     is_tail,
  input  wire                     found_before,
  output lkd_pkg::key_t           data,
  output logic                    found_here
);

  lkd_pkg::key_t data_next;

  assign found_here = found_before | (occupied & (data == key));

  always_comb begin
    data_next = data;
    if (ctl.insert) begin
      data_next = left_data;
    end else if (ctl.del_first) begin
      data_next = right_data;
    end else if (ctl.del_key && found_here) begin
      data_next = right_data;
    end else if (ctl.rotate) begin
      data_next = is_tail ? head_data : right_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

FILE: rtl/list_with_key_delete.sv
// list_with_key_delete: ordered key list held in a row of shifting cells
// depends on lkd_pkg and lkd_cell
//
//   channel  dir  handshake              payload
//   cmd      in   cmd_valid / cmd_stall  op, key
//   res      out  res_valid / res_stall  status, entry, entry_valid, last
//
// insert, delete key, delete first and delete last each give a single result beat
// dump takes the command, then gives an entry beat per rotation step of the cell row,
// back in order after the final one; no command is taken meanwhile
// rst clears the fill count and all handshake state
// a result held by res_stall also stalls the command side until it leaves
`default_nettype none

module list_with_key_delete (
  input  wire               clk,
  input  wire               rst,
  input  wire               cmd_valid,
  output logic              cmd_stall,
  input  wire  [2:0]        op,
  input  wire  signed [31:0] key,
  output logic              res_valid,
  input  wire               res_stall,
  output logic [1:0]        status,
  output logic signed [31:0] entry,
  output logic              entry_valid,
  output logic              last
);

  localparam int N = lkd_pkg::CAPACITY;
  localparam int CW = lkd_pkg::CNT_W;

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [CW-1:0]      remain;
  logic               dumping;
  logic               acc;
  logic               load;
  logic               is_empty;
  logic               is_full;
  lkd_pkg::cell_ctl_t ctl;
  lkd_pkg::key_t      cell_data [N];
  lkd_pkg::key_t      left_d    [N];
  lkd_pkg::key_t      right_d   [N];
  logic [N:0]         found;
  logic [N-1:0]       occ;
  logic [N-1:0]       tail;

  assign cmd_stall = dumping | (res_valid & res_stall);
  assign acc       = cmd_valid & ~cmd_stall;
  assign load      = ~res_valid | ~res_stall;
  assign is_empty  = (count == '0);
  assign is_full   = (count == CW'(N));

  assign ctl.insert    = acc & (op == lkd_pkg::OP_INSERT) & ~is_full;
  assign ctl.del_key   = acc & (op == lkd_pkg::OP_DEL_KEY);
  assign ctl.del_first = acc & (op == lkd_pkg::OP_DEL_FIRST) & ~is_empty;
  assign ctl.rotate    = dumping & load;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      left_d[i]  = (i == 0) ? key : cell_data[(i == 0) ? 0 : i - 1];
      right_d[i] = (i == N - 1) ? cell_data[i] : cell_data[(i == N - 1) ? i : i + 1];
      occ[i]     = (CW'(i) < count);
      tail[i]    = (CW'(i + 1) == count);
    end
  end

  assign found[0] = 1'b0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    lkd_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .key          (key),
      .left_data    (left_d[g]),
      .right_data   (right_d[g]),
      .head_data    (cell_data[0]),
      .occupied     (occ[g]),
      .is_tail      (tail[g]),
      .found_before (found[g]),
      .data         (cell_data[g]),
      .found_here   (found[g+1])
    );
  end

  always_comb begin
    count_next = count;
    if (ctl.insert) begin
      count_next = count + CW'(1);
    end else if (ctl.del_first) begin
      count_next = count - CW'(1);
    end else if (ctl.del_key && found[N]) begin
      count_next = count - CW'(1);
    end else if (acc && op == lkd_pkg::OP_DEL_LAST && !is_empty) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dumping   <= 1'b0;
      remain    <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      if (acc) begin
        case (op)
          lkd_pkg::OP_INSERT, lkd_pkg::OP_DEL_KEY,
          lkd_pkg::OP_DEL_FIRST, lkd_pkg::OP_DEL_LAST: begin
            res_valid <= 1'b1;
          end
          lkd_pkg::OP_DUMP: begin
            if (is_empty) begin
              res_valid <= 1'b1;
            end else begin
              dumping <= 1'b1;
              remain  <= count;
            end
          end
          default: begin
          end
        endcase
      end
      if (dumping && load) begin
        res_valid <= 1'b1;
        remain    <= remain - CW'(1);
        if (remain == CW'(1)) begin
          dumping <= 1'b0;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (acc) begin
      entry       <= '0;
      entry_valid <= 1'b0;
      last        <= 1'b1;
      case (op)
        lkd_pkg::OP_INSERT: begin
          status <= is_full ? lkd_pkg::ST_FULL : lkd_pkg::ST_OK;
        end
        lkd_pkg::OP_DEL_KEY: begin
          if (is_empty) begin
            status <= lkd_pkg::ST_EMPTY;
          end else begin
            status <= found[N] ? lkd_pkg::ST_OK : lkd_pkg::ST_NOTFOUND;
          end
        end
        lkd_pkg::OP_DEL_FIRST, lkd_pkg::OP_DEL_LAST, lkd_pkg::OP_DUMP: begin
          status <= is_empty ? lkd_pkg::ST_EMPTY : lkd_pkg::ST_OK;
        end
        default: begin
          status <= lkd_pkg::ST_OK;
        end
      endcase
    end else if (dumping && load) begin
      status      <= lkd_pkg::ST_OK;
      entry       <= cell_data[0];
      entry_valid <= 1'b1;
      last        <= (remain == CW'(1));
    end
  end

endmodule

`default_nettype wire

FILE: test/list_with_key_delete_test.sv
// list_with_key_delete_test: self-checking bench for the key list block, directed table then
// random segments, every beat checked against table status or list model; depends on lkd_pkg
`timescale 1ns / 1ps

module list_with_key_delete_test;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam lkd_pkg::key_t KEY_MAX = 32'h7fff_ffff;
  localparam lkd_pkg::key_t KEY_MIN = 32'h8000_0000;
  localparam int RANDOM_ITEMS = 380;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]    status;
    lkd_pkg::key_t entry;
    logic          entry_valid;
    logic          last;
  } beat_t;

  typedef struct {
    logic [2:0]    op;
    lkd_pkg::key_t key;
    int            reps;
    bit            typed;
    logic [1:0]    status;
  } step_row_t;

  typedef enum {SEG_MIX, SEG_FILL, SEG_DRAIN, SEG_DUMP} seg_kind_t;

  logic          clk;
  logic          rst = 1'b1;
  logic          cmd_valid = 1'b0;
  logic          cmd_stall;
  logic [2:0]    op = lkd_pkg::OP_INSERT;
  lkd_pkg::key_t key = '0;
  logic          res_valid;
  logic          res_stall = 1'b0;
  logic [1:0]    status;
  lkd_pkg::key_t entry;
  logic          entry_valid;
  logic          last;

  lkd_pkg::key_t list_keys [lkd_pkg::CAPACITY];
  int    list_len = 0;
  beat_t fresh_beats[$];
  beat_t pending_beats[$];
  int    mismatch_count = 0;
  int    cycle_count = 0;
  bit    no_idle = 1'b0;
  bit    hold_off_req = 1'b0;

  step_row_t directed_rows [27] = '{
    '{lkd_pkg::OP_DUMP,      32'd0,         1, 1'b1, lkd_pkg::ST_EMPTY},
    '{lkd_pkg::OP_DEL_KEY,   32'd0,         1, 1'b1, lkd_pkg::ST_EMPTY},
    '{lkd_pkg::OP_DEL_FIRST, 32'd0,         1, 1'b1, lkd_pkg::ST_EMPTY},
    '{lkd_pkg::OP_DEL_LAST,  32'd0,         1, 1'b1, lkd_pkg::ST_EMPTY},
    '{OP_SPARE_LO,           32'd0,         1, 1'b0, lkd_pkg::ST_OK},
    '{OP_SPARE_HI,           32'hffff_ffff, 1, 1'b0, lkd_pkg::ST_OK},
    '{lkd_pkg::OP_INSERT,    KEY_MAX,       1, 1'b1, lkd_pkg::ST_OK},
    '{lkd_pkg::OP_INSERT,    KEY_MIN,       1, 1'b1, lkd_pkg::ST_OK},
    '{lkd_pkg::OP_INSERT,    -32'sd1,       1, 1'b1, lkd_pkg::ST_OK},
    '{lkd_pkg::OP_INSERT,    32'd0,         1, 1'b1, lkd_pkg::ST_OK},
    '{lkd_pkg::OP_DUMP,      32'd0,         1, 1'b0, lkd_pkg::ST_OK},
    '{lkd_pkg::OP_DEL_KEY,   32'd12345,     1, 1'b1, lkd_pkg::ST_NOTFOUND},
    '{lkd_pkg::OP_INSERT,    32'd5,         1, 1'b1, lkd_pkg::ST_OK},
    '{lkd_pkg::OP_INSERT,    32'd5,         1, 1'b1, lkd_pkg::ST_OK},
    '{lkd_pkg::OP_DEL_KEY,   32'd5,         1, 1'b1, lkd_pkg::ST_OK},
    '{lkd_pkg::OP_DUMP,      32'd0,         1, 1'b0, lkd_pkg::ST_OK},
    '{lkd_pkg::OP_DEL_KEY,   KEY_MIN,       1, 1'b1, lkd_pkg::ST_OK},
    '{lkd_pkg::OP_DEL_KEY,   -32'sd1,       1, 1'b1, lkd_pkg::ST_OK},
    '{lkd_pkg::OP_DEL_FIRST, 32'd0,         1, 1'b1, lkd_pkg::ST_OK},
    '{lkd_pkg::OP_DEL_LAST,  32'd0,         1, 1'b1, lkd_pkg::ST_OK},
    '{lkd_pkg::OP_DUMP,      32'd0,         1, 1'b0, lkd_pkg::ST_OK},
    '{lkd_pkg::OP_DEL_LAST,  32'd0,         1, 1'b1, lkd_pkg::ST_OK},
    '{lkd_pkg::OP_DEL_KEY,   32'd3,         1, 1'b1, lkd_pkg::ST_EMPTY},
    '{lkd_pkg::OP_INSERT,    32'd1000, lkd_pkg::CAPACITY, 1'b1, lkd_pkg::ST_OK},
    '{lkd_pkg::OP_INSERT,    32'd7,         1, 1'b1, lkd_pkg::ST_FULL},
    '{lkd_pkg::OP_DUMP,      32'd0,         1, 1'b0, lkd_pkg::ST_OK},
    '{lkd_pkg::OP_DEL_LAST,  32'd0,    lkd_pkg::CAPACITY, 1'b1, lkd_pkg::ST_OK}
  };

  list_with_key_delete dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .op(op), .key(key),
    .res_valid(res_valid), .res_stall(res_stall),
    .status(status), .entry(entry), .entry_valid(entry_valid), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // list model: fills fresh_beats with the beats one command gives
  function automatic void predict_cmd(input logic [2:0] c_op, input lkd_pkg::key_t c_key);
    int i;
    int hit;
    logic [1:0] st;
    fresh_beats.delete();
    st = lkd_pkg::ST_OK;
    hit = -1;
    case (c_op)
      lkd_pkg::OP_INSERT: begin
        if (list_len >= lkd_pkg::CAPACITY) begin
          st = lkd_pkg::ST_FULL;
        end else begin
          for (i = list_len; i > 0; i--) list_keys[i] = list_keys[i-1];
          list_keys[0] = c_key;
          list_len++;
        end
      end
      lkd_pkg::OP_DEL_KEY: begin
        if (list_len == 0) begin
          st = lkd_pkg::ST_EMPTY;
        end else begin
          for (i = 0; i < list_len && hit < 0; i++) if (list_keys[i] == c_key) hit = i;
          if (hit < 0) begin
            st = lkd_pkg::ST_NOTFOUND;
          end else begin
            for (i = hit; i + 1 < list_len; i++) list_keys[i] = list_keys[i+1];
            list_len--;
          end
        end
      end
      lkd_pkg::OP_DEL_FIRST: begin
        if (list_len == 0) begin
          st = lkd_pkg::ST_EMPTY;
        end else begin
          for (i = 0; i + 1 < list_len; i++) list_keys[i] = list_keys[i+1];
          list_len--;
        end
      end
      lkd_pkg::OP_DEL_LAST: begin
        if (list_len == 0) st = lkd_pkg::ST_EMPTY;
        else list_len--;
      end
      lkd_pkg::OP_DUMP: begin
        if (list_len == 0) st = lkd_pkg::ST_EMPTY;
        else for (i = 0; i < list_len; i++)
          fresh_beats.push_back('{lkd_pkg::ST_OK, list_keys[i], 1'b1, (i + 1 == list_len)});
      end
      default: return;
    endcase
    if (c_op != lkd_pkg::OP_DUMP || list_len == 0)
      fresh_beats.push_back('{st, '0, 1'b0, 1'b1});
  endfunction

  function automatic lkd_pkg::key_t draw_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40 && list_len > 0) return list_keys[$urandom_range(0, list_len - 1)];
    if (r < 52) return lkd_pkg::key_t'($urandom_range(0, 7));
    if (r < 60) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return -32'sd1;
        2: return KEY_MAX;
        default: return KEY_MIN;
      endcase
    end
    return lkd_pkg::key_t'($urandom);
  endfunction

  function automatic logic [2:0] draw_op(input seg_kind_t kind);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    case (kind)
      SEG_FILL: begin
        if (r < 75) return lkd_pkg::OP_INSERT;
        if (r < 85) return lkd_pkg::OP_DEL_KEY;
        if (r < 90) return lkd_pkg::OP_DUMP;
        return lkd_pkg::OP_DEL_FIRST;
      end
      SEG_DRAIN: begin
        if (r < 30) return lkd_pkg::OP_DEL_KEY;
        if (r < 55) return lkd_pkg::OP_DEL_FIRST;
        if (r < 80) return lkd_pkg::OP_DEL_LAST;
        if (r < 90) return lkd_pkg::OP_INSERT;
        return lkd_pkg::OP_DUMP;
      end
      SEG_DUMP: begin
        if (r < 40) return lkd_pkg::OP_DUMP;
        if (r < 70) return lkd_pkg::OP_INSERT;
        return lkd_pkg::OP_DEL_KEY;
      end
      default: return 3'($urandom_range(lkd_pkg::OP_INSERT, lkd_pkg::OP_DUMP));
    endcase
  endfunction

  // offer one command, wait for it to be taken, then queue what it should give
  task automatic send_cmd(input logic [2:0] c_op, input lkd_pkg::key_t c_key, input bit typed,
                          input logic [1:0] typed_status);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    op <= c_op;
    key <= c_key;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predict_cmd(c_op, c_key);
    if (typed) pending_beats.push_back('{typed_status, '0, 1'b0, 1'b1});
    else foreach (fresh_beats[i]) pending_beats.push_back(fresh_beats[i]);
  endtask

  task automatic wait_all_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    int seg_len;
    logic [2:0] c_op;
    seg_kind_t kind;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r])
      for (n = 0; n < directed_rows[r].reps; n++)
        send_cmd(directed_rows[r].op, directed_rows[r].key + n, directed_rows[r].typed,
                 directed_rows[r].status);

    // long receiver hold-off with the sender pushing hard
    no_idle = 1'b1;
    hold_off_req = 1'b1;
    for (n = 0; n < 40; n++) send_cmd(draw_op(SEG_FILL), draw_key(), 1'b0, lkd_pkg::ST_OK);
    no_idle = 1'b0;
    wait_all_results();

    n = 40;
    while (n < RANDOM_ITEMS) begin
      kind = seg_kind_t'($urandom_range(0, 3));
      seg_len = $urandom_range(10, 40);
      if ($urandom_range(0, 3) == 0) wait_all_results();
      no_idle = ($urandom_range(0, 4) == 0);
      repeat (seg_len) begin
        c_op = draw_op(kind);
        send_cmd(c_op, draw_key(), 1'b0, lkd_pkg::ST_OK);
        if (c_op <= lkd_pkg::OP_DUMP) n++;
      end
    end
    no_idle = 1'b0;

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_beats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side stall pattern
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (hold_off_req) gap = HOLD_CYCLES;
      else gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        res_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        hold_off_req = 1'b0;
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    beat_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected beat: status %0d entry %0d entry_valid %0b last %0b",
                   status, entry, entry_valid, last);
      end else begin
        want = pending_beats.pop_front();
        if (status !== want.status || entry !== want.entry ||
            entry_valid !== want.entry_valid || last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: exp status %0d entry %0d valid %0b last %0b, got %0d %0d %0b %0b",
                     want.status, want.entry, want.entry_valid, want.last,
                     status, entry, entry_valid, last);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
